>>> rtl/ucsc_pkg.sv
`default_nettype none
package ucsc_pkg;

	localparam logic ACT_CHAR  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef enum logic [1:0] {
		KIND_CHAR   = 2'd0,
		KIND_END    = 2'd1,
		KIND_REFUSE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		REASON_TERM  = 2'd0,
		REASON_LIMIT = 2'd1,
		REASON_FLUSH = 2'd2
	} reason_t;

	localparam logic [16:0] OPEN_MAX = 17'h1FFFF;

	typedef struct packed {
		logic       action;
		logic [7:0] byte_0;
		logic [7:0] byte_1;
		logic [7:0] byte_2;
		logic [7:0] byte_3;
		logic [2:0] char_width;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte_0;
		logic [7:0]  out_byte_1;
		logic [7:0]  out_byte_2;
		logic [7:0]  out_byte_3;
		logic [2:0]  out_width;
		reason_t     end_reason;
		logic [16:0] chunk_bytes;
		logic [31:0] chunk_number;
		logic        last_result;
	} out_item_t;

	typedef struct packed {
		logic [2:0] width;
		logic       term;
		logic       newline;
		logic       valid;
	} char_class_t;

	function automatic out_item_t mk_char(in_item_t it, logic [2:0] w);
		out_item_t r;
		r = '0;
		r.kind       = KIND_CHAR;
		r.end_reason = REASON_TERM;
		r.out_byte_0 = it.byte_0;
		r.out_byte_1 = (w >= 3'd2) ? it.byte_1 : 8'h00;
		r.out_byte_2 = (w >= 3'd3) ? it.byte_2 : 8'h00;
		r.out_byte_3 = (w >= 3'd4) ? it.byte_3 : 8'h00;
		r.out_width  = w;
		return r;
	endfunction

	function automatic out_item_t mk_end(reason_t why, logic [16:0] bytes, logic [31:0] num);
		out_item_t r;
		r = '0;
		r.kind         = KIND_END;
		r.end_reason   = why;
		r.chunk_bytes  = bytes;
		r.chunk_number = num;
		return r;
	endfunction

	function automatic out_item_t mk_refuse(logic [16:0] bytes);
		out_item_t r;
		r = '0;
		r.kind        = KIND_REFUSE;
		r.end_reason  = REASON_TERM;
		r.chunk_bytes = bytes;
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/ucsc_classify.sv
`default_nettype none
module ucsc_classify (
	input  ucsc_pkg::in_item_t    item,
	output ucsc_pkg::char_class_t cls
);
	import ucsc_pkg::*;

	logic [2:0] w;
	logic [2:0] need;
	logic [7:0] lo;
	logic [7:0] hi;
	logic       lead_ok;
	logic       ascii;
	logic       cont2;
	logic       cont3;

	always_comb begin
		if (item.char_width == 3'd0) begin
			w = 3'd1;
		end else if (item.char_width > 3'd4) begin
			w = 3'd4;
		end else begin
			w = item.char_width;
		end
	end

	always_comb begin
		need    = 3'd1;
		lo      = 8'h80;
		hi      = 8'hBF;
		lead_ok = 1'b1;
		ascii   = (item.byte_0 <= 8'h7F);
		if (ascii) begin
			need = 3'd1;
		end else if (item.byte_0 >= 8'hC2 && item.byte_0 <= 8'hDF) begin
			need = 3'd2;
		end else if (item.byte_0 >= 8'hE0 && item.byte_0 <= 8'hEF) begin
			need = 3'd3;
			if (item.byte_0 == 8'hE0) begin
				lo = 8'hA0;
			end else if (item.byte_0 == 8'hED) begin
				hi = 8'h9F;
			end
		end else if (item.byte_0 >= 8'hF0 && item.byte_0 <= 8'hF4) begin
			need = 3'd4;
			if (item.byte_0 == 8'hF0) begin
				lo = 8'h90;
			end else if (item.byte_0 == 8'hF4) begin
				hi = 8'h8F;
			end
		end else begin
			lead_ok = 1'b0;
		end
	end

	assign cont2 = (item.byte_2[7:6] == 2'b10);
	assign cont3 = (item.byte_3[7:6] == 2'b10);

	always_comb begin
		cls.width = w;
		if (ascii) begin
			cls.valid = (w == 3'd1);
		end else begin
			cls.valid = lead_ok && (w == need) && (item.byte_1 >= lo) && (item.byte_1 <= hi)
				&& (need < 3'd3 || cont2) && (need < 3'd4 || cont3);
		end
		cls.newline = (w == 3'd1) && (item.byte_0 == 8'h0A);
		cls.term    = 1'b0;
		if (w == 3'd1) begin
			cls.term = (item.byte_0 == 8'h0A) || (item.byte_0 == 8'h21)
				|| (item.byte_0 == 8'h3F) || (item.byte_0 == 8'h3B);
		end else if (w == 3'd3) begin
			// Full-width ideographic full stop and the full-width ! ? ;
			cls.term = (item.byte_0 == 8'hE3 && item.byte_1 == 8'h80 && item.byte_2 == 8'h82)
				|| (item.byte_0 == 8'hEF && item.byte_1 == 8'hBC
				&& (item.byte_2 == 8'h81 || item.byte_2 == 8'h9F || item.byte_2 == 8'h9B));
		end
	end

endmodule
`default_nettype wire

>>> rtl/ucsc_engine.sv
`default_nettype none
module ucsc_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  ucsc_pkg::in_item_t    item,
	input  ucsc_pkg::char_class_t cls,
	input  logic                  cfg_fire,
	input  logic [15:0]           cfg_data,
	output ucsc_pkg::out_item_t   res [3],
	output logic [1:0]            res_n
);
	import ucsc_pkg::*;

	logic [15:0] limit_q;
	logic [16:0] open_q;
	logic        split_q;
	logic        inv_q;
	logic [31:0] cnt_q;

	logic [16:0] open_d;
	logic        split_d;
	logic        inv_d;
	logic [31:0] cnt_d;

	logic [17:0] sum_a;
	logic [16:0] open_app;
	logic        pre;
	logic        post;
	logic [16:0] open2;
	logic        inv2;
	logic [31:0] cnt1;
	logic [31:0] cnt_mid;
	out_item_t   r [3];
	logic [1:0]  n;

	assign sum_a    = {1'b0, open_q} + 18'(cls.width);
	assign open_app = sum_a[17] ? OPEN_MAX : sum_a[16:0];
	assign cnt1     = cnt_q + 32'd1;

	// The limit is checked once before the append (would overflow) and once after (reached).
	assign pre     = (limit_q != 16'd0) && (open_q != 17'd0) && (sum_a > {2'b00, limit_q});
	assign open2   = pre ? 17'(cls.width) : open_app;
	assign inv2    = (pre ? 1'b0 : inv_q) | ~cls.valid;
	assign cnt_mid = pre ? cnt1 : cnt_q;
	assign post    = (limit_q != 16'd0) && (open2 >= {1'b0, limit_q});

	always_comb begin
		r[0]    = '0;
		r[1]    = '0;
		r[2]    = '0;
		n       = 2'd0;
		open_d  = open_q;
		split_d = split_q;
		inv_d   = inv_q;
		cnt_d   = cnt_q;
		if (item.action == ACT_FLUSH) begin
			if (open_q != 17'd0) begin
				n = 2'd1;
				if (inv_q) begin
					r[0] = mk_refuse(open_q);
				end else begin
					r[0]   = mk_end(REASON_FLUSH, open_q, cnt1);
					open_d = '0;
					inv_d  = 1'b0;
					cnt_d  = cnt1;
				end
			end
		end else if (cls.term) begin
			split_d = 1'b1;
			if (!split_q && open_q != 17'd0) begin
				if (cls.newline) begin
					r[0] = mk_end(REASON_TERM, open_q, cnt1);
					n    = 2'd1;
				end else begin
					r[0] = mk_char(item, cls.width);
					r[1] = mk_end(REASON_TERM, open_app, cnt1);
					n    = 2'd2;
				end
				open_d = '0;
				inv_d  = 1'b0;
				cnt_d  = cnt1;
			end
		end else begin
			if (pre) begin
				r[0] = mk_end(REASON_LIMIT, open_q, cnt1);
				r[1] = mk_char(item, cls.width);
				if (post) begin
					r[2] = mk_end(REASON_LIMIT, open2, cnt_mid + 32'd1);
				end
				n = post ? 2'd3 : 2'd2;
			end else begin
				r[0] = mk_char(item, cls.width);
				if (post) begin
					r[1] = mk_end(REASON_LIMIT, open2, cnt_mid + 32'd1);
				end
				n = post ? 2'd2 : 2'd1;
			end
			open_d  = post ? 17'd0 : open2;
			inv_d   = post ? 1'b0 : inv2;
			split_d = post;
			cnt_d   = cnt_mid + 32'(post);
		end
		unique case (n)
			2'd1:    r[0].last_result = 1'b1;
			2'd2:    r[1].last_result = 1'b1;
			2'd3:    r[2].last_result = 1'b1;
			default: ;
		endcase
	end

	assign res   = r;
	assign res_n = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= '0;
			open_q  <= '0;
			split_q <= 1'b0;
			inv_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (cfg_fire) begin
				limit_q <= cfg_data;
			end
			if (fire) begin
				open_q  <= open_d;
				split_q <= split_d;
				inv_q   <= inv_d;
				cnt_q   <= cnt_d;
			end
		end
	end

endmodule
`default_nettype wire

>>> rtl/ucsc_result_fifo.sv
`default_nettype none
module ucsc_result_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_n,
	input  ucsc_pkg::out_item_t push_data [3],
	output logic                room,
	output logic                out_valid,
	input  logic                out_ready,
	output ucsc_pkg::out_item_t out_data
);
	import ucsc_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	out_item_t     mem [DEPTH];
	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic          pop;
	logic [AW-1:0] waddr [3];
	logic [AW-1:0] head_nx;
	logic [AW-1:0] tail_nx;

	function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [1:0] inc);
		logic [AW:0] s;
		s = {1'b0, base} + (AW + 1)'(inc);
		if (s >= (AW + 1)'(DEPTH)) begin
			s = s - (AW + 1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != '0);
	assign out_data  = mem[head_q];
	// One input can add three results, so new requests wait for three free slots.
	assign room      = (count_q <= CW'(DEPTH - 3));

	assign waddr[0] = tail_q;
	assign waddr[1] = wrap_add(tail_q, 2'd1);
	assign waddr[2] = wrap_add(tail_q, 2'd2);
	assign head_nx  = wrap_add(head_q, 2'd1);
	assign tail_nx  = wrap_add(tail_q, push_n);

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push_n) begin
				mem[waddr[i]] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (pop) begin
				head_q <= head_nx;
			end
			tail_q  <= tail_nx;
			count_q <= count_q + CW'(push_n) - CW'(pop);
		end
	end

endmodule
`default_nettype wire

>>> rtl/utf8_sentence_chunker.sv
// Each accepted request writes its results into a result queue, which presents them on out.
// Throughput: one request per cycle while each gives at most one result and out is not
// stalled; a request that gives two or three results fills that many entries of a
// result queue of FIFO_DEPTH entries that accepts requests while three slots are free.
// Reset: asynchronous, active low; clears the limit, chunk state and the queue.
`default_nettype none
module utf8_sentence_chunker #(
	parameter int FIFO_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ucsc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ucsc_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import ucsc_pkg::*;

	char_class_t cls;
	out_item_t   res [3];
	logic [1:0]  res_n;
	logic        fire;
	logic        room;

	assign in_ready  = room;
	assign fire      = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	ucsc_classify u_classify (
		.item (in_data),
		.cls  (cls)
	);

	ucsc_engine u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (fire),
		.item     (in_data),
		.cls      (cls),
		.cfg_fire (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.res      (res),
		.res_n    (res_n)
	);

	ucsc_result_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (fire ? res_n : 2'd0),
		.push_data (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
`default_nettype wire

>>> sim/chunk_checker.sv
module chunk_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  ucsc_pkg::in_item_t  in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  ucsc_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	input  logic                cfg_ready,
	input  logic [15:0]         cfg_data,
	output int                  mismatches,
	output int                  outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import ucsc_pkg::*;

	localparam logic [7:0]  CH_NEWLINE     = 8'h0A;
	localparam logic [7:0]  CH_BANG        = 8'h21;
	localparam logic [7:0]  CH_QUESTION    = 8'h3F;
	localparam logic [7:0]  CH_SEMICOLON   = 8'h3B;
	localparam logic [23:0] FW_FULL_STOP   = 24'hE38082;
	localparam logic [23:0] FW_BANG        = 24'hEFBC81;
	localparam logic [23:0] FW_QUESTION    = 24'hEFBC9F;
	localparam logic [23:0] FW_SEMICOLON   = 24'hEFBC9B;

	logic [15:0] chunk_limit;
	logic [16:0] open_bytes;
	logic        split_pending;
	logic        chunk_invalid;
	logic [31:0] chunks_emitted;

	out_item_t step_results [0:2];
	int        step_count;
	out_item_t expected_results [$];
	int        fail_total;

	function automatic bit utf8_well_formed(in_item_t it, logic [2:0] w);
		logic [7:0] lo;
		logic [7:0] hi;
		logic [2:0] need;
		lo = 8'h80;
		hi = 8'hBF;
		if (it.byte_0 <= 8'h7F)
			return w == 3'd1;
		if (it.byte_0 >= 8'hC2 && it.byte_0 <= 8'hDF) begin
			need = 3'd2;
		end else if (it.byte_0 >= 8'hE0 && it.byte_0 <= 8'hEF) begin
			need = 3'd3;
			if (it.byte_0 == 8'hE0)
				lo = 8'hA0;
			else if (it.byte_0 == 8'hED)
				hi = 8'h9F;
		end else if (it.byte_0 >= 8'hF0 && it.byte_0 <= 8'hF4) begin
			need = 3'd4;
			if (it.byte_0 == 8'hF0)
				lo = 8'h90;
			else if (it.byte_0 == 8'hF4)
				hi = 8'h8F;
		end else begin
			return 1'b0;
		end
		if (w != need || it.byte_1 < lo || it.byte_1 > hi)
			return 1'b0;
		if (need >= 3'd3 && it.byte_2[7:6] != 2'b10)
			return 1'b0;
		if (need == 3'd4 && it.byte_3[7:6] != 2'b10)
			return 1'b0;
		return 1'b1;
	endfunction

	function automatic string show_result(out_item_t r);
		return {$sformatf("kind=%0d bytes=%h_%h_%h_%h width=%0d",
				r.kind, r.out_byte_0, r.out_byte_1, r.out_byte_2, r.out_byte_3,
				r.out_width),
			$sformatf(" reason=%0d chunk_bytes=%0d number=%0d last=%0b",
				r.end_reason, r.chunk_bytes, r.chunk_number, r.last_result)};
	endfunction

	task automatic emit_char(in_item_t it, logic [2:0] w);
		out_item_t  r;
		logic [17:0] grown;
		r = '0;
		r.kind = KIND_CHAR;
		r.end_reason = REASON_TERM;
		r.out_byte_0 = it.byte_0;
		if (w >= 3'd2)
			r.out_byte_1 = it.byte_1;
		if (w >= 3'd3)
			r.out_byte_2 = it.byte_2;
		if (w >= 3'd4)
			r.out_byte_3 = it.byte_3;
		r.out_width = w;
		step_results[step_count] = r;
		step_count++;
		grown = open_bytes + w;
		open_bytes = (grown > OPEN_MAX) ? OPEN_MAX : grown[16:0];
	endtask

	task automatic close_chunk(reason_t why);
		out_item_t r;
		chunks_emitted = chunks_emitted + 32'd1;
		r = '0;
		r.kind = KIND_END;
		r.end_reason = why;
		r.chunk_bytes = open_bytes;
		r.chunk_number = chunks_emitted;
		step_results[step_count] = r;
		step_count++;
		open_bytes = '0;
		chunk_invalid = 1'b0;
	endtask

	task automatic predict_chunk_results(in_item_t it);
		logic [2:0]  w;
		logic [17:0] grown;
		bit          term;
		bit          newline;
		out_item_t   r;
		term = 1'b0;
		newline = 1'b0;
		w = it.char_width;
		if (w == 3'd0)
			w = 3'd1;
		else if (w > 3'd4)
			w = 3'd4;

		if (it.action == ACT_FLUSH) begin
			if (open_bytes == '0)
				return;
			if (chunk_invalid) begin
				// A refused flush leaves the chunk exactly as it was.
				r = '0;
				r.kind = KIND_REFUSE;
				r.end_reason = REASON_TERM;
				r.chunk_bytes = open_bytes;
				step_results[step_count] = r;
				step_count++;
			end else begin
				close_chunk(REASON_FLUSH);
			end
			return;
		end

		if (w == 3'd1) begin
			if (it.byte_0 == CH_NEWLINE) begin
				term = 1'b1;
				newline = 1'b1;
			end else if (it.byte_0 == CH_BANG || it.byte_0 == CH_QUESTION ||
					it.byte_0 == CH_SEMICOLON) begin
				term = 1'b1;
			end
		end else if (w == 3'd3) begin
			if ({it.byte_0, it.byte_1, it.byte_2} inside {FW_FULL_STOP, FW_BANG,
					FW_QUESTION, FW_SEMICOLON})
				term = 1'b1;
		end

		if (term) begin
			if (!split_pending && open_bytes != '0) begin
				if (!newline)
					emit_char(it, w);
				close_chunk(REASON_TERM);
			end
			split_pending = 1'b1;
		end else begin
			grown = open_bytes + w;
			if (chunk_limit != '0 && open_bytes != '0 && grown > chunk_limit)
				close_chunk(REASON_LIMIT);
			emit_char(it, w);
			if (!utf8_well_formed(it, w))
				chunk_invalid = 1'b1;
			split_pending = 1'b0;
			if (chunk_limit != '0 && open_bytes >= chunk_limit) begin
				close_chunk(REASON_LIMIT);
				split_pending = 1'b1;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		string     diff;
		if (!arst_n) begin
			chunk_limit = '0;
			open_bytes = '0;
			split_pending = 1'b0;
			chunk_invalid = 1'b0;
			chunks_emitted = '0;
			expected_results.delete();
			fail_total = 0;
			mismatches <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				chunk_limit = cfg_data;

			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					fail_total++;
					$display("time %0t: result with nothing expected: expected none, got %s",
						$time, show_result(out_data));
				end else begin
					want = expected_results.pop_front();
					diff = "";
					if (out_data.kind !== want.kind)                 diff = {diff, " kind"};
					if (out_data.out_byte_0 !== want.out_byte_0)     diff = {diff, " out_byte_0"};
					if (out_data.out_byte_1 !== want.out_byte_1)     diff = {diff, " out_byte_1"};
					if (out_data.out_byte_2 !== want.out_byte_2)     diff = {diff, " out_byte_2"};
					if (out_data.out_byte_3 !== want.out_byte_3)     diff = {diff, " out_byte_3"};
					if (out_data.out_width !== want.out_width)       diff = {diff, " out_width"};
					if (out_data.end_reason !== want.end_reason)     diff = {diff, " end_reason"};
					if (out_data.chunk_bytes !== want.chunk_bytes)   diff = {diff, " chunk_bytes"};
					if (out_data.chunk_number !== want.chunk_number) diff = {diff, " chunk_number"};
					if (out_data.last_result !== want.last_result)   diff = {diff, " last_result"};
					if (diff != "") begin
						fail_total++;
						$display("time %0t: wrong%s: expected %s, got %s",
							$time, diff, show_result(want), show_result(out_data));
					end
				end
			end

			if (in_valid && in_ready) begin
				step_count = 0;
				predict_chunk_results(in_data);
				if (step_count > 0)
					step_results[step_count - 1].last_result = 1'b1;
				for (int i = 0; i < step_count; i++)
					expected_results = {expected_results, step_results[i]};
			end

			mismatches <= fail_total;
			outstanding <= expected_results.size();
		end
	end

endmodule

>>> sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ucsc_pkg::*;

	localparam int PHASE_REQUESTS = 49;
	localparam in_item_t FLUSH_REQ = {ACT_FLUSH, 32'h0000_0000, 3'd0};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	int mismatches;
	int outstanding;
	bit quiet;

	utf8_sentence_chunker dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	chunk_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_data     (in_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 2);
		if (roll < 97)
			return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	// Mostly well-formed text with random content; the rest is raw noise and flushes.
	function automatic in_item_t random_request();
		in_item_t r;
		int       pick;
		r.action = ACT_CHAR;
		r.byte_0 = 8'($urandom_range(0, 255));
		r.byte_1 = 8'($urandom_range(0, 255));
		r.byte_2 = 8'($urandom_range(0, 255));
		r.byte_3 = 8'($urandom_range(0, 255));
		r.char_width = 3'($urandom_range(0, 7));
		pick = $urandom_range(0, 99);
		if (pick < 7) begin
			r.action = ACT_FLUSH;
		end else if (pick < 26) begin
			// raw noise: leave it as drawn
		end else if (pick < 40) begin
			r.char_width = 3'd1;
			case ($urandom_range(0, 3))
				0: r.byte_0 = 8'h21;
				1: r.byte_0 = 8'h3F;
				2: r.byte_0 = 8'h3B;
				default: r.byte_0 = 8'h0A;
			endcase
		end else if (pick < 48) begin
			r.char_width = 3'd3;
			case ($urandom_range(0, 3))
				0: {r.byte_0, r.byte_1, r.byte_2} = 24'hE38082;
				1: {r.byte_0, r.byte_1, r.byte_2} = 24'hEFBC81;
				2: {r.byte_0, r.byte_1, r.byte_2} = 24'hEFBC9F;
				default: {r.byte_0, r.byte_1, r.byte_2} = 24'hEFBC9B;
			endcase
		end else begin
			r.char_width = 3'($urandom_range(1, 4));
			case (r.char_width)
				3'd1: r.byte_0 = 8'($urandom_range(8'h00, 8'h7F));
				3'd2: begin
					r.byte_0 = 8'($urandom_range(8'hC2, 8'hDF));
					r.byte_1 = 8'($urandom_range(8'h80, 8'hBF));
				end
				3'd3: begin
					r.byte_0 = 8'($urandom_range(8'hE0, 8'hEF));
					if (r.byte_0 == 8'hE0)
						r.byte_1 = 8'($urandom_range(8'hA0, 8'hBF));
					else if (r.byte_0 == 8'hED)
						r.byte_1 = 8'($urandom_range(8'h80, 8'h9F));
					else
						r.byte_1 = 8'($urandom_range(8'h80, 8'hBF));
					r.byte_2 = 8'($urandom_range(8'h80, 8'hBF));
				end
				default: begin
					r.byte_0 = 8'($urandom_range(8'hF0, 8'hF4));
					if (r.byte_0 == 8'hF0)
						r.byte_1 = 8'($urandom_range(8'h90, 8'hBF));
					else if (r.byte_0 == 8'hF4)
						r.byte_1 = 8'($urandom_range(8'h80, 8'h8F));
					else
						r.byte_1 = 8'($urandom_range(8'h80, 8'hBF));
					r.byte_2 = 8'($urandom_range(8'h80, 8'hBF));
					r.byte_3 = 8'($urandom_range(8'h80, 8'hBF));
				end
			endcase
		end
		return r;
	endfunction

	// The valid line is only dropped during a gap, so a back-to-back request never
	// sees a low and a high scheduled in the same step.
	task automatic send_request(input in_item_t req);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_data <= req;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Dropped terminators and empty flushes give no result, so settle waits on past the
	// last expected result to cover any work still in flight.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_limit(input logic [15:0] value);
		settle();
		cfg_data <= value;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		int stall;
		stall = 0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				out_ready <= 1'b0;
				stall--;
			end else begin
				out_ready <= 1'b1;
				if (!quiet && $urandom_range(0, 9) < 3)
					stall = pick_gap();
			end
		end
	end

	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		logic [15:0] limit;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// No size limit after reset.
		send_request(FLUSH_REQ);
		send_request({ACT_CHAR, 32'h2100_0000, 3'd1});
		send_request({ACT_CHAR, 32'hC3A9_0000, 3'd2});
		send_request({ACT_CHAR, 32'hE282_AC00, 3'd3});
		send_request({ACT_CHAR, 32'hF09F_9880, 3'd4});
		send_request({ACT_CHAR, 32'h3B00_0000, 3'd1});
		send_request({ACT_CHAR, 32'h3F00_0000, 3'd1});
		send_request({ACT_CHAR, 32'h41FF_FFFF, 3'd1});
		send_request({ACT_CHAR, 32'hEFBC_81FF, 3'd3});
		send_request({ACT_CHAR, 32'h0000_0000, 3'd1});
		send_request({ACT_CHAR, 32'hE380_8200, 3'd3});
		send_request({ACT_CHAR, 32'h7F00_0000, 3'd1});
		send_request({ACT_CHAR, 32'hEFBC_9F00, 3'd3});
		send_request({ACT_CHAR, 32'hFF00_0000, 3'd1});
		send_request({ACT_CHAR, 32'hEFBC_9B00, 3'd3});
		send_request({ACT_CHAR, 32'hC3A9_0000, 3'd0});
		send_request(FLUSH_REQ);
		send_request({ACT_CHAR, 32'h0A00_0000, 3'd1});
		send_request({ACT_CHAR, 32'h41FF_00FF, 3'd7});
		send_request({ACT_CHAR, 32'h2100_0000, 3'd1});
		send_request({ACT_CHAR, 32'h7A00_0000, 3'd1});
		send_request(FLUSH_REQ);

		// A four-byte limit: split after append, terminator after a split, and a
		// wide character that splits both before and after it is appended.
		write_limit(16'd4);
		send_request({ACT_CHAR, 32'h6100_0000, 3'd1});
		send_request({ACT_CHAR, 32'h6200_0000, 3'd1});
		send_request({ACT_CHAR, 32'h6300_0000, 3'd1});
		send_request({ACT_CHAR, 32'h6400_0000, 3'd1});
		send_request({ACT_CHAR, 32'h2100_0000, 3'd1});
		send_request({ACT_CHAR, 32'h6100_0000, 3'd1});
		send_request({ACT_CHAR, 32'hF09F_9880, 3'd4});

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: limit = 16'd1;
				1: limit = 16'hFFFF;
				2: limit = 16'($urandom_range(2, 12));
				3: limit = 16'd0;
				4: limit = 16'd3;
				5: limit = 16'($urandom_range(0, 65535));
				default: limit = 16'($urandom_range(5, 20));
			endcase
			quiet = (phase == 2);
			write_limit(limit);
			repeat (PHASE_REQUESTS) begin
				send_request(random_request());
				if ($urandom_range(0, 39) == 0)
					settle();
			end
		end
		quiet = 1'b0;

		settle();
		if (mismatches == 0 && outstanding == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
